FILE: hw/rtl/suset_pkg.sv
// ----------------------------------------------------------------------------
// suset_pkg: shared types and constants of the sorted set intersection block
// Command codes, queue entry type and sizing constants.
// ----------------------------------------------------------------------------
package suset_pkg;

	// Entries per set; also bounds the number of distinct common values.
	localparam int CAPACITY    = 32;
	localparam int DATA_WIDTH  = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	// Command queue between front and back; depth is a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_COMPUTE     = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_COMPUTE     = 2'd2
	} op_t;

	typedef struct packed {
		op_t                          op;
		logic signed [DATA_WIDTH-1:0] value;
	} q_entry_t;

endpackage

FILE: hw/rtl/suset_item_if.sv
// ----------------------------------------------------------------------------
// suset_item_if: input channel of the set intersection block
// Valid/ready channel carrying a command and an element value.
// ----------------------------------------------------------------------------
interface suset_item_if;
	import suset_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [1:0]                   command;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);

endinterface

FILE: hw/rtl/suset_result_if.sv
// ----------------------------------------------------------------------------
// suset_result_if: result channel of the set intersection block
// Valid/ready channel carrying one common value and its flags.
// ----------------------------------------------------------------------------
interface suset_result_if;
	import suset_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] common_value;
	logic                         last;
	logic                         none_found;
	logic                         overflow;

	modport source (output valid, output common_value, output last,
		output none_found, output overflow, input ready);
	modport sink   (input valid, input common_value, input last,
		input none_found, input overflow, output ready);

endinterface

FILE: hw/rtl/sorted_unique_set_intersection.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_intersection: sorted, duplicate-free set intersection
// Loads two sets, then emits their common values in ascending order.
// ----------------------------------------------------------------------------
// A load transaction (command 0 or 1) is taken by the back end only while it
// is idle; loads then stream at one per cycle. A compute transaction
// (command 2) runs a scan that compares one pair per cycle against the
// second-set memory read port: each element of the first set is fetched,
// then compared with the second-set entries in turn up to its first match
// or the end of the second set. Matches drop straight into a sorted chain
// that discards repeats; results then leave at one per cycle while the
// receiver is ready, ascending, the last one flagged, and a single marker
// transaction with none_found set when nothing is shared. Overflow reports
// whether any load was dropped on a full set since the previous compute. A
// four-entry command queue in front keeps accepting transactions, until it
// is full, while the back end scans or waits for results to be taken;
// command 3 is accepted and dropped. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_unique_set_intersection (
	input  logic           clk,
	input  logic           arst_n,
	suset_item_if.sink     items,
	suset_result_if.source results
);
	import suset_pkg::*;

	// Decoupling queue head between front and back.
	logic     head_valid;
	logic     head_ready;
	q_entry_t head;

	// Accept, classify and queue commands.
	suset_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.head_valid (head_valid),
		.head       (head),
		.head_ready (head_ready)
	);

	// Load sets, scan, sort and emit.
	suset_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_ready (head_ready),
		.results    (results)
	);

endmodule

FILE: hw/rtl/suset_front.sv
// ----------------------------------------------------------------------------
// suset_front: command front end
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module suset_front (
	input  logic                clk,
	input  logic                arst_n,
	suset_item_if.sink          items,
	output logic                head_valid,
	output suset_pkg::q_entry_t head,
	input  logic                head_ready
);
	import suset_pkg::*;

	q_entry_t          queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              take;
	logic              push;
	logic              pop;
	q_entry_t          entry;

	assign items.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign take        = items.valid && items.ready;

	// Classify; the unused command is taken and dropped.
	always_comb begin
		entry.value = items.value;
		entry.op    = OP_LOAD_FIRST;
		push        = 1'b0;
		case (items.command)
			CMD_LOAD_FIRST: begin
				entry.op = OP_LOAD_FIRST;
				push     = take;
			end
			CMD_LOAD_SECOND: begin
				entry.op = OP_LOAD_SECOND;
				push     = take;
			end
			CMD_COMPUTE: begin
				entry.op = OP_COMPUTE;
				push     = take;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign head_valid = (cnt_q != '0);
	assign head       = queue_q[rd_ptr_q];
	assign pop        = head_valid && head_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= QCNT_W'(QUEUE_DEPTH)) && !(pop && (cnt_q == '0)))
		else $error("command queue count out of range");

endmodule

FILE: hw/rtl/suset_back.sv
// ----------------------------------------------------------------------------
// suset_back: execution back end
// Holds both sets, scans for common values, keeps them in a sorted chain, emits.
// ----------------------------------------------------------------------------
module suset_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  suset_pkg::q_entry_t head,
	output logic                head_ready,
	suset_result_if.source      results
);
	import suset_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD_A = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                       state_q;
	logic signed [DATA_WIDTH-1:0] mem_a [CAPACITY];
	logic signed [DATA_WIDTH-1:0] mem_b [CAPACITY];
	logic signed [DATA_WIDTH-1:0] a_rd_q;
	logic signed [DATA_WIDTH-1:0] b_rd_q;
	logic [CNT_W-1:0]             fcnt_q;
	logic [CNT_W-1:0]             scnt_q;
	logic                         ovf_q;
	logic [CNT_W-1:0]             i_q;
	logic [IDX_W-1:0]             j_q;
	logic [IDX_W-1:0]             b_raddr;

	logic signed [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [CAPACITY-1:0]          vld_q;
	logic [CAPACITY-1:0]          vld_up;
	logic [CAPACITY-1:0]          big;
	logic                         hit;
	logic                         match;
	logic                         insert;
	logic                         shift;
	logic                         last_item;
	logic                         take;
	logic                         we_a;
	logic                         we_b;
	logic                         full_a;
	logic                         full_b;
	logic                         scan_end;

	assign head_ready = (state_q == ST_IDLE);
	assign take       = head_valid && head_ready;
	assign full_a     = (fcnt_q == CNT_W'(CAPACITY));
	assign full_b     = (scnt_q == CNT_W'(CAPACITY));
	assign we_a       = take && (head.op == OP_LOAD_FIRST) && !full_a;
	assign we_b       = take && (head.op == OP_LOAD_SECOND) && !full_b;

	assign match    = (a_rd_q == b_rd_q);
	assign scan_end = ((CNT_W'(j_q) + 1'b1) == scnt_q);
	assign b_raddr  = (state_q == ST_RD_A) ? '0 : (j_q + 1'b1);

	// Set memories: one write, one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[fcnt_q[IDX_W-1:0]] <= head.value;
		end
		if (we_b) begin
			mem_b[scnt_q[IDX_W-1:0]] <= head.value;
		end
		if (state_q == ST_RD_A) begin
			a_rd_q <= mem_a[i_q[IDX_W-1:0]];
		end
		b_rd_q <= mem_b[b_raddr];
	end

	// Position search and duplicate check over the chain.
	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < CAPACITY; k++) begin
			big[k] = !vld_q[k] || (cell_q[k] > a_rd_q);
			hit    = hit || (vld_q[k] && (cell_q[k] == a_rd_q));
		end
	end

	assign insert    = (state_q == ST_CMP) && match && !hit;
	assign vld_up    = vld_q >> 1;
	assign last_item = !vld_up[0];
	assign shift     = results.valid && results.ready && vld_q[0];

	// Sorted insertion chain; shifts down one cell per emitted result.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_chain
		logic signed [DATA_WIDTH-1:0] below;
		logic                         below_big;
		logic                         below_vld;
		logic signed [DATA_WIDTH-1:0] above;
		logic                         above_vld;

		if (k == 0) begin : g_bot
			assign below     = a_rd_q;
			assign below_big = 1'b0;
			assign below_vld = 1'b1;
		end else begin : g_mid
			assign below     = cell_q[k-1];
			assign below_big = big[k-1];
			assign below_vld = vld_q[k-1];
		end

		if (k == CAPACITY - 1) begin : g_top
			assign above     = cell_q[k];
			assign above_vld = 1'b0;
		end else begin : g_low
			assign above     = cell_q[k+1];
			assign above_vld = vld_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (insert) begin
				if (big[k]) begin
					cell_q[k] <= below_big ? below : a_rd_q;
				end
			end else if (shift) begin
				cell_q[k] <= above;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (insert) begin
				vld_q[k] <= below_vld;
			end else if (shift) begin
				vld_q[k] <= above_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fcnt_q  <= '0;
			scnt_q  <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (head.op)
							OP_LOAD_FIRST: begin
								if (full_a) begin
									ovf_q <= 1'b1;
								end else begin
									fcnt_q <= fcnt_q + 1'b1;
								end
							end
							OP_LOAD_SECOND: begin
								if (full_b) begin
									ovf_q <= 1'b1;
								end else begin
									scnt_q <= scnt_q + 1'b1;
								end
							end
							OP_COMPUTE: begin
								i_q     <= '0;
								state_q <= ST_RD_A;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD_A: begin
					j_q <= '0;
					if ((i_q == fcnt_q) || (scnt_q == '0)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (match || scan_end) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RD_A;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (results.valid && results.ready && last_item) begin
						fcnt_q  <= '0;
						scnt_q  <= '0;
						ovf_q   <= 1'b0;
						i_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid        = (state_q == ST_EMIT);
	assign results.common_value = vld_q[0] ? cell_q[0] : '0;
	assign results.last         = last_item;
	assign results.none_found   = !vld_q[0];
	assign results.overflow     = ovf_q;

	a_chain_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_up & ~vld_q) == '0)
		else $error("chain valid bits are not a prefix");

	if (CAPACITY > 1) begin : g_sorted_chk
		a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			vld_q[1] |-> (cell_q[0] < cell_q[1]))
			else $error("chain head not strictly ascending");
	end

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last)
		|=> (fcnt_q == '0) && (scnt_q == '0) && !ovf_q && (vld_q == '0))
		else $error("state not cleared after final result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fcnt_q <= CNT_W'(CAPACITY)) && (scnt_q <= CNT_W'(CAPACITY))
		&& (i_q <= fcnt_q))
		else $error("set count out of range");

endmodule

FILE: sim/suset_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// suset_checker: prediction and result comparison for the set intersection
// Watches both channels, keeps its own copy of the two sets, works out the
// sorted common values of every compute and compares each result transaction
// against the oldest one still awaited.
// ----------------------------------------------------------------------------
module suset_checker (
	input  logic    clk,
	input  logic    arst_n,
	suset_item_if   items,
	suset_result_if results,
	output int      errors,
	output int      pending
);
	import suset_pkg::*;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] common_value;
		logic                         last;
		logic                         none_found;
		logic                         overflow;
	} hit_t;

	logic signed [DATA_WIDTH-1:0] set_mem [2][CAPACITY];
	int                           set_count [2];
	logic                         overflow_seen;
	hit_t                         awaited_hits [$];

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: result mismatch: %s", $time, what);
	endtask

	// Append to one set, or drop the value and flag it when the set is full.
	task automatic load_element(input int which, input logic signed [DATA_WIDTH-1:0] val);
		if (set_count[which] >= CAPACITY) begin
			overflow_seen = 1'b1;
		end else begin
			set_mem[which][set_count[which]] = val;
			set_count[which]++;
		end
	endtask

	// Queue the ascending, repeat-free common values, or the single marker.
	task automatic predict_intersection();
		logic signed [DATA_WIDTH-1:0] common [$];
		logic signed [DATA_WIDTH-1:0] cand;
		hit_t                         hit;
		bit                           found;
		int                           pos;
		for (int i = 0; i < set_count[0]; i++) begin
			cand  = set_mem[0][i];
			found = 1'b0;
			for (int j = 0; j < set_count[1]; j++) begin
				if (set_mem[1][j] == cand)
					found = 1'b1;
			end
			if (found) begin
				pos = 0;
				while (pos < common.size() && common[pos] < cand)
					pos++;
				if (pos == common.size() || common[pos] != cand)
					common.insert(pos, cand);
			end
		end
		if (common.size() == 0) begin
			hit.common_value = '0;
			hit.last         = 1'b1;
			hit.none_found   = 1'b1;
			hit.overflow     = overflow_seen;
			awaited_hits.push_back(hit);
		end else begin
			foreach (common[k]) begin
				hit.common_value = common[k];
				hit.last         = (k == common.size() - 1);
				hit.none_found   = 1'b0;
				hit.overflow     = overflow_seen;
				awaited_hits.push_back(hit);
			end
		end
		set_count[0]  = 0;
		set_count[1]  = 0;
		overflow_seen = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		hit_t want;
		if (!arst_n) begin
			set_count[0]  = 0;
			set_count[1]  = 0;
			overflow_seen = 1'b0;
			awaited_hits.delete();
			errors        = 0;
			pending       = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (awaited_hits.size() == 0) begin
					report_mismatch($sformatf("unexpected result, value %0d",
						results.common_value));
				end else begin
					want = awaited_hits.pop_front();
					if (results.common_value !== want.common_value)
						report_mismatch($sformatf("common_value %0d, expected %0d",
							results.common_value, want.common_value));
					if (results.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b",
							results.last, want.last));
					if (results.none_found !== want.none_found)
						report_mismatch($sformatf("none_found %b, expected %b",
							results.none_found, want.none_found));
					if (results.overflow !== want.overflow)
						report_mismatch($sformatf("overflow %b, expected %b",
							results.overflow, want.overflow));
				end
			end
			if (items.valid && items.ready) begin
				case (items.command)
					OP_LOAD_FIRST:  load_element(0, items.value);
					OP_LOAD_SECOND: load_element(1, items.value);
					OP_COMPUTE:     predict_intersection();
					default:        ;
				endcase
			end
			pending = awaited_hits.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for sorted_unique_set_intersection
// Drives load and compute transactions in random bursts, stalls the result
// side on its own pattern and leaves prediction and comparison to the
// checker instance that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
	import suset_pkg::*;

	// Command 3 is not decoded by the block; it must be swallowed silently.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [DATA_WIDTH-1:0] VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] VALUE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	// Longest legal quiet stretch is a compute over two full sets plus a long
	// receiver stall; this is many times that.
	localparam int IDLE_LIMIT = 20000;

	localparam int ITEM_TARGET = 220;

	logic clk = 1'b0;
	logic arst_n;

	suset_item_if   items ();
	suset_result_if results ();

	int errors;
	int pending;
	int burst_left;
	int items_sent;

	logic signed [DATA_WIDTH-1:0] value_pool [$];

	sorted_unique_set_intersection dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	suset_checker intersect_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Draw a value: small numbers collide often, extremes hit the sign edges,
	// full-width words toggle every bit.
	function automatic logic signed [DATA_WIDTH-1:0] fresh_value();
		case ($urandom_range(0, 3))
			0: fresh_value = $urandom_range(0, 40) - 20;
			1: begin
				case ($urandom_range(0, 3))
					0:       fresh_value = VALUE_MIN;
					1:       fresh_value = VALUE_MAX;
					2:       fresh_value = '0;
					default: fresh_value = '1;
				endcase
			end
			default: fresh_value = $urandom;
		endcase
	endfunction

	// Prefer the per-pair pool so that the two sets actually share values.
	function automatic logic signed [DATA_WIDTH-1:0] pick_value();
		if (value_pool.size() != 0 && $urandom_range(0, 3) != 0)
			pick_value = value_pool[$urandom_range(0, value_pool.size() - 1)];
		else
			pick_value = fresh_value();
	endfunction

	// Mostly small sets; now and then a large one that may reach or pass capacity.
	function automatic int set_size();
		if ($urandom_range(0, 11) == 0)
			set_size = $urandom_range(20, CAPACITY + 4);
		else
			set_size = $urandom_range(0, 8);
	endfunction

	// Present one transaction at the falling edge and hold it until accepted.
	// At the end of a burst, drop valid for a random gap first.
	task automatic send_item(input logic [1:0] cmd, input logic signed [DATA_WIDTH-1:0] val);
		if (burst_left == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			// Long bursts give stretches with no sender idling at all.
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(30, 80);
			else
				burst_left = $urandom_range(1, 12);
		end
		items.valid   <= 1'b1;
		items.command <= cmd;
		items.value   <= val;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Hold the sender until every awaited result has been taken.
	task automatic drain_results();
		items.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// Load two sets from a shared pool in random interleaving, sprinkle in an
	// ignored command now and then, and close with a compute.
	task automatic load_and_intersect(input int n_first, input int n_second);
		int left_first;
		int left_second;
		left_first  = n_first;
		left_second = n_second;
		value_pool.delete();
		repeat ($urandom_range(1, 10))
			value_pool.push_back(fresh_value());
		while (left_first + left_second > 0) begin
			if ($urandom_range(0, 19) == 0)
				send_item(CMD_UNUSED, $urandom);
			if (left_second == 0 || (left_first > 0 && $urandom_range(0, 1) == 0)) begin
				send_item(OP_LOAD_FIRST, pick_value());
				left_first--;
			end else begin
				send_item(OP_LOAD_SECOND, pick_value());
				left_second--;
			end
		end
		send_item(OP_COMPUTE, $urandom);
	endtask

	// Result side: switch between always ready, light, medium and heavy
	// stalling, picking a new mode at random times.
	initial begin : result_taker
		int mode;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				case (mode)
					0:       results.ready <= 1'b1;
					1:       results.ready <= ($urandom_range(0, 3) != 0);
					2:       results.ready <= ($urandom_range(0, 1) == 1);
					default: results.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// End the run when neither channel moves for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((items.valid && items.ready) || (results.valid && results.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		items.valid   = 1'b0;
		items.command = OP_LOAD_FIRST;
		items.value   = '0;
		arst_n        = 1'b0;
		burst_left    = 0;
		items_sent    = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Compute on two empty sets: expect the lone no-match marker.
		send_item(OP_COMPUTE, '0);

		// Extremes, zero, minus one and a repeat on both sides; the common
		// values must come out once each, sorted by signed order.
		send_item(OP_LOAD_FIRST, VALUE_MIN);
		send_item(OP_LOAD_FIRST, VALUE_MAX);
		send_item(OP_LOAD_FIRST, '0);
		send_item(OP_LOAD_FIRST, '1);
		send_item(OP_LOAD_FIRST, 5);
		send_item(OP_LOAD_FIRST, 5);
		send_item(OP_LOAD_SECOND, 5);
		send_item(OP_LOAD_SECOND, '1);
		send_item(OP_LOAD_SECOND, VALUE_MAX);
		send_item(OP_LOAD_SECOND, 7);
		send_item(OP_LOAD_SECOND, VALUE_MIN);
		send_item(OP_LOAD_SECOND, 5);
		// The unused command must leave both sets untouched.
		send_item(CMD_UNUSED, 32'h5555_5555);
		send_item(OP_COMPUTE, '1);

		// Disjoint sets, then an empty first set.
		send_item(OP_LOAD_FIRST, 1);
		send_item(OP_LOAD_SECOND, 2);
		send_item(OP_COMPUTE, 32'hAAAA_AAAA);
		send_item(OP_LOAD_SECOND, 3);
		send_item(OP_COMPUTE, '0);

		// Pause with nothing in flight before the random part.
		drain_results();

		// Overfill both sets so loads get dropped and overflow is reported;
		// the next compute must show the flag cleared again unless its own loads overflow.
		load_and_intersect(CAPACITY + 2, CAPACITY + 1);

		while (items_sent < ITEM_TARGET) begin
			load_and_intersect(set_size(), set_size());
			// Back-to-back compute on freshly cleared sets.
			if ($urandom_range(0, 9) == 0)
				send_item(OP_COMPUTE, $urandom);
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end

		drain_results();
		// Give a stray late result room to show up.
		repeat (64) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/suset_pkg.sv
hw/rtl/suset_item_if.sv
hw/rtl/suset_result_if.sv
hw/rtl/suset_front.sv
hw/rtl/suset_back.sv
hw/rtl/sorted_unique_set_intersection.sv
sim/suset_checker.sv
sim/testbench.sv
